// File: hw/rtl/frw_pkg.sv
// ----------------------------------------------------------------------------
// frw_pkg
// shared types and codes for the binary indexed tree range sum block
// ----------------------------------------------------------------------------
package frw_pkg;

  localparam int PosW   = 10;
  localparam int RangeW = 11;
  localparam int DataW  = 64;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_QHI   = 6'b001000,
    ST_QLO   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

endpackage

// File: hw/rtl/frw_if.sv
// ----------------------------------------------------------------------------
// frw_req_if / frw_rsp_if
// valid/ready channels for update and query requests and for range sums
// ----------------------------------------------------------------------------
interface frw_req_if;
  logic                            valid;
  logic                            ready;
  frw_pkg::func_e                  func;
  logic [frw_pkg::PosW-1:0]        position;
  frw_pkg::data_t                  delta;
  logic [frw_pkg::RangeW-1:0]      range_low;
  logic [frw_pkg::RangeW-1:0]      range_high;

  modport source (output valid, func, position, delta, range_low, range_high,
                  input ready);
  modport sink   (input valid, func, position, delta, range_low, range_high,
                  output ready);
endinterface

interface frw_rsp_if;
  logic           valid;
  logic           ready;
  frw_pkg::data_t range_total;

  modport source (output valid, range_total, input ready);
  modport sink   (input valid, range_total, output ready);
endinterface

// File: hw/rtl/frw_ram.sv
// ----------------------------------------------------------------------------
// frw_ram
// simple dual-port tree node memory, one write and one registered read
// ----------------------------------------------------------------------------
module frw_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fenwick_range_sum.sv
// ----------------------------------------------------------------------------
// fenwick_range_sum
// binary indexed tree of SIZE signed 64-bit nodes with point add and range sum
// ----------------------------------------------------------------------------
// update: reads each node on the upward walk and writes it back with delta added
// query: adds the nodes on the high bound's prefix walk, subtracts the nodes on
// the low bound's walk; one node memory read a cycle, one request in flight
// at a time; a finished sum waits in the output register while the next request
// is taken; after reset a clearing pass zeroes the node memory, no request is
// taken until it ends
// ----------------------------------------------------------------------------
module fenwick_range_sum #(
  parameter int SIZE = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  frw_req_if.sink       req_i,
  frw_rsp_if.source     rsp_o
);

  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int NW = $clog2(2 * SIZE + 1);
  localparam int CW = (NW > frw_pkg::RangeW) ? NW : frw_pkg::RangeW;

  frw_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [NW-1:0]   node_q, node_d;
  logic [NW-1:0]   lo_q, lo_d;
  frw_pkg::data_t  delta_q, delta_d;
  frw_pkg::data_t  acc_q, acc_d;
  logic            pend_q, pend_d;
  logic            pend_neg_q, pend_neg_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic            out_valid_q, out_valid_d;
  frw_pkg::data_t  out_data_q, out_data_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  frw_pkg::data_t  ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  frw_pkg::data_t  ram_rdata;

  logic [CW-1:0]   size_c;
  logic [CW-1:0]   pos_ext;
  logic [CW-1:0]   pos_inc;
  logic [CW-1:0]   hi_ext;
  logic [CW-1:0]   lo_ext;
  logic [CW-1:0]   hi_sat;
  logic [CW-1:0]   lo_sat;
  logic [NW-1:0]   node_low;
  logic [NW-1:0]   node_dec;
  logic            in_acc;

  frw_ram #(
    .DEPTH (SIZE),
    .WIDTH (frw_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign size_c   = CW'(SIZE);
  assign pos_ext  = CW'(req_i.position);
  assign pos_inc  = pos_ext + CW'(1);
  assign hi_ext   = CW'(req_i.range_high);
  assign lo_ext   = CW'(req_i.range_low);
  assign hi_sat   = (hi_ext > size_c) ? size_c : hi_ext;
  assign lo_sat   = (lo_ext > size_c) ? size_c : lo_ext;
  assign node_low = node_q & (~node_q + NW'(1));
  assign node_dec = node_q - NW'(1);

  assign req_i.ready     = (state_q == frw_pkg::ST_IDLE);
  assign in_acc          = req_i.valid && req_i.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.range_total = out_data_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    lo_d        = lo_q;
    delta_d     = delta_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    pend_neg_d  = pend_neg_q;
    pend_addr_d = pend_addr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata + delta_q;
    ram_re      = 1'b0;
    ram_raddr   = node_dec[AW-1:0];

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    // sum in flight from the previous read
    if (pend_q && (state_q != frw_pkg::ST_UPD)) begin
      acc_d = pend_neg_q ? (acc_q - ram_rdata) : (acc_q + ram_rdata);
    end

    unique case (state_q)
      frw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(SIZE - 1)) begin
          state_d = frw_pkg::ST_IDLE;
        end
      end
      frw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (req_i.func == frw_pkg::FUNC_QUERY) begin
            node_d  = hi_sat[NW-1:0];
            lo_d    = lo_sat[NW-1:0];
            acc_d   = '0;
            state_d = frw_pkg::ST_QHI;
          end else if (pos_ext < size_c) begin
            node_d  = pos_inc[NW-1:0];
            delta_d = req_i.delta;
            state_d = frw_pkg::ST_UPD;
          end
        end
      end
      frw_pkg::ST_UPD: begin
        // read next node while the previous one is written back
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (node_q <= NW'(SIZE)) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = node_dec[AW-1:0];
          node_d      = node_q + node_low;
        end else if (!pend_q) begin
          state_d = frw_pkg::ST_IDLE;
        end
      end
      frw_pkg::ST_QHI: begin
        if (node_q != '0) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_neg_d = 1'b0;
          node_d     = node_q - node_low;
        end else begin
          node_d  = lo_q;
          state_d = frw_pkg::ST_QLO;
        end
      end
      frw_pkg::ST_QLO: begin
        if (node_q != '0) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_neg_d = 1'b1;
          node_d     = node_q - node_low;
        end else if (!pend_q) begin
          state_d = frw_pkg::ST_DONE;
        end
      end
      frw_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = frw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = frw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frw_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    lo_q        <= lo_d;
    delta_q     <= delta_d;
    acc_q       <= acc_d;
    pend_neg_q  <= pend_neg_d;
    pend_addr_q <= pend_addr_d;
    out_data_q  <= out_data_d;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the binary indexed tree range sum block: point adds
// and range queries go in through a valid/ready request channel, and every
// range sum that comes back is compared with a local tree model kept in step
// with the accepted requests, under random gaps and output stalls
// ----------------------------------------------------------------------------
module tb;

  localparam int NODES   = 1024;
  localparam int NRANDOM = 900;

  typedef struct {
    frw_pkg::func_e                func;
    logic [frw_pkg::PosW-1:0]      position;
    frw_pkg::data_t                delta;
    logic [frw_pkg::RangeW-1:0]    range_low;
    logic [frw_pkg::RangeW-1:0]    range_high;
  } frw_item_t;

  logic clk_i;
  logic rst_ni;

  frw_req_if req_if ();
  frw_rsp_if rsp_if ();

  fenwick_range_sum #(
    .SIZE (NODES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [frw_pkg::DataW-1:0] node_mem [NODES] = '{default: '0};
  frw_item_t        pending_reqs [$];
  frw_pkg::data_t   sum_q [$];

  frw_item_t        next_req;
  frw_item_t        on_wire;
  bit               held;
  int unsigned      hold_cnt;
  int unsigned      stall_cnt;
  bit               drv_calm;
  bit               mon_calm;

  int unsigned      n_total;
  int unsigned      n_accepted;
  int unsigned      n_updates;
  int unsigned      n_queries;
  int unsigned      n_checked;
  int unsigned      n_errors;

  // tree model
  function automatic void node_add(int unsigned pos, logic [frw_pkg::DataW-1:0] amount);
    int unsigned n;
    n = pos + 1;
    while (n <= NODES) begin
      node_mem[n-1] = node_mem[n-1] + amount;
      n = n + (n & (~n + 1));
    end
  endfunction

  function automatic logic [frw_pkg::DataW-1:0] prefix_upto(int unsigned count);
    logic [frw_pkg::DataW-1:0] acc;
    int unsigned      n;
    acc = '0;
    n   = (count > NODES) ? NODES : count;
    while (n > 0) begin
      acc = acc + node_mem[n-1];
      n   = n - (n & (~n + 1));
    end
    return acc;
  endfunction

  function automatic void apply_request(frw_item_t it);
    n_accepted++;
    if (it.func == frw_pkg::FUNC_ADD) begin
      node_add(it.position, it.delta);
      n_updates++;
    end else begin
      sum_q.push_back(frw_pkg::data_t'(prefix_upto(it.range_high) -
                                       prefix_upto(it.range_low)));
      n_queries++;
    end
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // stimulus helpers, unused fields carry random bits
  function automatic void push_add(logic [frw_pkg::PosW-1:0] pos, frw_pkg::data_t amount);
    frw_item_t it;
    it.func       = frw_pkg::FUNC_ADD;
    it.position   = pos;
    it.delta      = amount;
    it.range_low  = frw_pkg::RangeW'($urandom);
    it.range_high = frw_pkg::RangeW'($urandom);
    pending_reqs.push_back(it);
  endfunction

  function automatic void push_query(logic [frw_pkg::RangeW-1:0] lo,
                                     logic [frw_pkg::RangeW-1:0] hi);
    frw_item_t it;
    it.func       = frw_pkg::FUNC_QUERY;
    it.position   = frw_pkg::PosW'($urandom);
    it.delta      = {$urandom, $urandom};
    it.range_low  = lo;
    it.range_high = hi;
    pending_reqs.push_back(it);
  endfunction

  function automatic frw_pkg::data_t rand_delta();
    int v;
    case ($urandom_range(0, 6))
      0, 1: begin
        v = $urandom_range(0, 200);
        return frw_pkg::data_t'(v - 100);
      end
      2, 3: return {$urandom, $urandom};
      4:    return 64'h7fff_ffff_ffff_ffff;
      5:    return 64'h8000_0000_0000_0000;
      default: return -64'sd1;
    endcase
  endfunction

  function automatic logic [frw_pkg::RangeW-1:0] rand_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return frw_pkg::RangeW'(NODES);
      2:       return frw_pkg::RangeW'($urandom_range(NODES + 1, 2047));
      default: return frw_pkg::RangeW'($urandom_range(0, NODES));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = frw_pkg::FUNC_ADD;
    req_if.position   = '0;
    req_if.delta      = '0;
    req_if.range_low  = '0;
    req_if.range_high = '0;
    rsp_if.ready      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // request list
  initial begin
    int unsigned hot;
    int unsigned lo;
    int unsigned hi;

    // empty tree, extremes, wrap at one node, alternating position bits
    push_query(11'd0, 11'd1024);
    push_add(10'd0, 64'h7fff_ffff_ffff_ffff);
    push_add(10'd1023, 64'h8000_0000_0000_0000);
    push_add(10'd512, -64'sd1);
    push_add(10'd511, 64'sd1);
    push_add(10'd0, 64'sd1);
    push_add(10'd341, 64'sd5);
    push_add(10'd682, -64'sd7);
    push_query(11'd0, 11'd1);
    push_query(11'd0, 11'd1024);
    push_query(11'd1023, 11'd1024);
    // empty ranges
    push_query(11'd512, 11'd512);
    push_query(11'd1024, 11'd1024);
    push_query(11'd0, 11'd0);
    // low bound above high bound
    push_query(11'd1000, 11'd3);
    // bounds past the end saturate, then two spans inside the tree
    push_query(11'd2047, 11'd0);
    push_query(11'd0, 11'd2047);
    push_query(11'd1025, 11'd1030);
    push_query(11'd0, 11'd1040);
    push_query(11'd511, 11'd513);
    push_query(11'd1, 11'd1023);

    hot = $urandom_range(0, NODES - 1);
    for (int i = 0; i < NRANDOM; i++) begin
      if ($urandom_range(0, 49) == 0) hot = $urandom_range(0, NODES - 1);
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 9) < 3)
          push_add(frw_pkg::PosW'((hot + $urandom_range(0, 8)) % NODES), rand_delta());
        else
          push_add(frw_pkg::PosW'($urandom), rand_delta());
      end else if ($urandom_range(0, 4) == 0) begin
        lo = (hot > 4) ? hot - $urandom_range(0, 4) : 0;
        hi = hot + $urandom_range(0, 12);
        if ($urandom_range(0, 5) == 0)
          push_query(frw_pkg::RangeW'(hi), frw_pkg::RangeW'(lo));
        else
          push_query(frw_pkg::RangeW'(lo), frw_pkg::RangeW'(hi));
      end else begin
        push_query(rand_bound(), rand_bound());
      end
    end
    n_total = pending_reqs.size();
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.func       <= frw_pkg::FUNC_ADD;
      req_if.position   <= '0;
      req_if.delta      <= '0;
      req_if.range_low  <= '0;
      req_if.range_high <= '0;
      held              = 1'b0;
      hold_cnt          = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_request(on_wire);
      end
      if (!req_if.valid || req_if.ready) begin
        if (!held && pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          held     = 1'b1;
          if ($urandom_range(0, 39) == 0) drv_calm = ~drv_calm;
          hold_cnt = draw_gap(drv_calm);
        end
        if (held && hold_cnt == 0) begin
          on_wire           = next_req;
          held              = 1'b0;
          req_if.valid      <= 1'b1;
          req_if.func       <= next_req.func;
          req_if.position   <= next_req.position;
          req_if.delta      <= next_req.delta;
          req_if.range_low  <= next_req.range_low;
          req_if.range_high <= next_req.range_high;
        end else begin
          req_if.valid <= 1'b0;
          if (held) hold_cnt--;
        end
      end
    end
  end

  // range sum monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_cnt    = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (sum_q.size() == 0) begin
          $display("%t range sum %0d with no query outstanding", $time,
                   rsp_if.range_total);
          n_errors++;
        end else begin
          frw_pkg::data_t want;
          want = sum_q.pop_front();
          n_checked++;
          if (rsp_if.range_total !== want) begin
            $display("%t range sum mismatch: expected %0d actual %0d", $time,
                     want, rsp_if.range_total);
            n_errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) mon_calm = ~mon_calm;
        stall_cnt = draw_gap(mon_calm);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      rsp_if.ready <= (stall_cnt == 0);
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (n_accepted < n_total || sum_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("covered %0d updates and %0d range queries, %0d sums checked",
             n_updates, n_queries, n_checked);
    $display("%0d mismatches or stray sums", n_errors);
    if (n_errors == 0) begin
      $display("PASS fenwick_range_sum");
    end else begin
      $display("FAIL fenwick_range_sum");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("%t run did not finish, %0d of %0d requests taken, %0d sums owed", $time,
             n_accepted, n_total, sum_q.size());
    $display("FAIL fenwick_range_sum");
    $finish;
  end

endmodule

// File: fenwick_range_sum.f
hw/rtl/frw_pkg.sv
hw/rtl/frw_if.sv
hw/rtl/frw_ram.sv
hw/rtl/fenwick_range_sum.sv
dv/tb.sv
